@@ sv/ddsplit_pkg.sv @@
// Shared types and constants for the decimal digit splitter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ddsplit_pkg;

  // Default for the MAX_DIGITS parameter; the field length saturates here.
  localparam int unsigned MaxDigitsDef = 10;

  // Length as stored in the job queue; covers MAX_DIGITS up to 15.
  localparam int unsigned LenW = 4;

  // Columns move left by this much per digit.
  localparam logic [7:0] ColumnStep = 8'd6;

  // floor(v / 10) == (v * DivMagic) >> DivShift for every 32-bit v.
  localparam logic [63:0] DivMagic = 64'h0000_0000_CCCC_CCCD;
  localparam int unsigned DivShift = 35;

  typedef struct packed {
    logic [6:0]  start_column;
    logic [5:0]  row_position;
    logic [7:0]  field_length;
    logic [31:0] number_value;
    logic [1:0]  pixel_colour;
  } item_t;

  typedef struct packed {
    logic [3:0] decimal_digit;
    logic [7:0] digit_column;
    logic [5:0] digit_row;
    logic [1:0] digit_colour;
    logic       last_digit;
  } result_t;

  // One queued number with its length already saturated.
  typedef struct packed {
    logic [6:0]      column;
    logic [5:0]      row;
    logic [1:0]      colour;
    logic [LenW-1:0] len;
    logic [31:0]     value;
  } job_t;

  // What travels with the digits from the converter to the emitter.
  typedef struct packed {
    logic [6:0] column;
    logic [5:0] row;
    logic [1:0] colour;
  } place_t;

endpackage

`default_nettype wire

@@ sv/ddsplit_front.sv @@
// Front end: accepts numbers, saturates the length, drops zero-length ones
// and keeps a two-entry job queue. Depends on ddsplit_pkg.
`default_nettype none

module ddsplit_front #(
  parameter int unsigned MAX_DIGITS = ddsplit_pkg::MaxDigitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire ddsplit_pkg::item_t  item_i,
  output logic                     busy_o,
  output logic                     job_valid_o,
  output ddsplit_pkg::job_t        job_o,
  input  wire logic                job_pop_i
);

  ddsplit_pkg::job_t ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       accept, push, pop;
  ddsplit_pkg::job_t job_new;

  assign busy_o      = (cnt_q == 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = ent_q[rd_ptr_q];

  assign accept = start_i && !busy_o;
  // A zero length produces no digits, so such a number never enters the queue.
  assign push   = accept && (item_i.field_length != 8'd0);
  assign pop    = job_valid_o && job_pop_i;

  always_comb begin
    job_new.column = item_i.start_column;
    job_new.row    = item_i.row_position;
    job_new.colour = item_i.pixel_colour;
    job_new.value  = item_i.number_value;
    if (item_i.field_length > 8'(MAX_DIGITS)) begin
      job_new.len = ddsplit_pkg::LenW'(MAX_DIGITS);
    end else begin
      job_new.len = item_i.field_length[ddsplit_pkg::LenW-1:0];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= job_new;
    end
  end

endmodule

`default_nettype wire

@@ sv/ddsplit_conv.sv @@
// Converter: splits one queued number into decimal digits, one digit per cycle,
// through a reciprocal multiply by one tenth. Depends on ddsplit_pkg.
`default_nettype none

module ddsplit_conv #(
  parameter int unsigned MAX_DIGITS = ddsplit_pkg::MaxDigitsDef,
  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1),
  localparam int unsigned IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        job_valid_i,
  input  wire ddsplit_pkg::job_t           job_i,
  output logic                             job_pop_o,
  output logic                             hand_valid_o,
  input  wire logic                        hand_ready_i,
  output logic [MAX_DIGITS-1:0][3:0]       digits_o,
  output logic [CntW-1:0]                  count_o,
  output ddsplit_pkg::place_t              place_o
);

  logic                      busy_q, done_q;
  logic [31:0]               val_q;
  logic [CntW-1:0]           k_q, n_q, len_q;
  logic [MAX_DIGITS-1:0][3:0] dig_q;
  ddsplit_pkg::place_t       place_q;

  logic            hand, load, step;
  logic [31:0]     cur_val, quot;
  logic [CntW-1:0] cur_k, cur_n, cur_len, k_next;
  logic [63:0]     prod;
  logic [31:0]     rem_full;
  logic [3:0]      rem;

  assign hand      = done_q && hand_ready_i;
  assign load      = job_valid_i && !busy_q && (!done_q || hand);
  assign job_pop_o = load;
  assign step      = busy_q || load;

  // The first digit is taken straight from the queue head in the load cycle.
  assign cur_val = busy_q ? val_q : job_i.value;
  assign cur_k   = busy_q ? k_q : '0;
  assign cur_n   = busy_q ? n_q : CntW'(1);
  assign cur_len = busy_q ? len_q : CntW'(job_i.len);
  assign k_next  = cur_k + CntW'(1);

  assign prod     = 64'(cur_val) * ddsplit_pkg::DivMagic;
  assign quot     = 32'(prod >> ddsplit_pkg::DivShift);
  assign rem_full = cur_val - ((quot << 3) + (quot << 1));
  assign rem      = rem_full[3:0];

  assign hand_valid_o = done_q;
  assign digits_o     = dig_q;
  assign count_o      = n_q;
  assign place_o      = place_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      // A one-digit number loaded in the handoff cycle is done right away.
      if (step && (k_next == cur_len)) begin
        done_q <= 1'b1;
      end else if (hand) begin
        done_q <= 1'b0;
      end
      if (step) begin
        busy_q <= (k_next != cur_len);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      len_q          <= CntW'(job_i.len);
      place_q.column <= job_i.column;
      place_q.row    <= job_i.row;
      place_q.colour <= job_i.colour;
    end
    if (step) begin
      dig_q[cur_k[IdxW-1:0]] <= rem;
      val_q                  <= quot;
      k_q                    <= k_next;
      // The digit count tracks the highest nonzero digit, never below one.
      n_q                    <= (rem != 4'd0) ? k_next : cur_n;
    end
  end

endmodule

`default_nettype wire

@@ sv/ddsplit_emit.sv @@
// Emitter: sends the converted digits out one beat per cycle, least
// significant first, with the running column. Depends on ddsplit_pkg.
`default_nettype none

module ddsplit_emit #(
  parameter int unsigned MAX_DIGITS = ddsplit_pkg::MaxDigitsDef,
  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1),
  localparam int unsigned IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        hand_valid_i,
  output logic                             hand_ready_o,
  input  wire logic [MAX_DIGITS-1:0][3:0]  digits_i,
  input  wire logic [CntW-1:0]             count_i,
  input  wire ddsplit_pkg::place_t         place_i,
  output logic                             res_valid_o,
  output ddsplit_pkg::result_t             res_o
);

  logic                       active_q;
  logic [MAX_DIGITS-1:0][3:0] dig_q;
  logic [CntW-1:0]            k_q, n_q;
  logic [7:0]                 col_q;
  logic [5:0]                 row_q;
  logic [1:0]                 colour_q;

  logic            last, hand;
  logic [CntW-1:0] k_next;

  assign k_next       = k_q + CntW'(1);
  assign last         = (k_next == n_q);
  assign hand_ready_o = !active_q || last;
  assign hand         = hand_valid_i && hand_ready_o;

  assign res_valid_o         = active_q;
  assign res_o.decimal_digit = dig_q[k_q[IdxW-1:0]];
  assign res_o.digit_column  = col_q;
  assign res_o.digit_row     = row_q;
  assign res_o.digit_colour  = colour_q;
  assign res_o.last_digit    = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (hand) begin
      active_q <= 1'b1;
    end else if (active_q && last) begin
      active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hand) begin
      dig_q    <= digits_i;
      n_q      <= count_i;
      k_q      <= '0;
      col_q    <= {1'b0, place_i.column};
      row_q    <= place_i.row;
      colour_q <= place_i.colour;
    end else if (active_q) begin
      k_q   <= k_next;
      col_q <= col_q - ddsplit_pkg::ColumnStep;
    end
  end

endmodule

`default_nettype wire

@@ sv/decimal_digit_splitter_core.sv @@
// Top level of the decimal digit splitter: front queue, converter, emitter.
// Depends on ddsplit_pkg, ddsplit_front, ddsplit_conv and ddsplit_emit.
//
// Usage: drive item_i and raise start_i; the number is taken at a rising
// edge where start_i is high and busy_o is low. busy_o rises only when the
// two-entry job queue is full. A field length of zero is taken and gives no
// beat; longer lengths are cut to MAX_DIGITS.
// Each digit leaves as one beat on res_o, marked by res_valid_o for exactly
// one cycle, least significant digit first; last_digit marks the final beat
// of a number. Beats of one number come in consecutive cycles.
// For an idle block a number passes through the job queue, the converter
// and the emitter's registers before its first beat is shown, and that beat
// is taken in the cycle it is shown.
// The converter produces one digit per cycle while it holds a number
// (through a 32x32 reciprocal multiplier), and the emitter overlaps with it,
// so the converter can load the next number while the emitter sends the last.
// Reset clears the queue and all valid flags; no beat is pending after it.
// The receiver cannot stall: every beat is taken in the cycle it is shown.
`default_nettype none

module decimal_digit_splitter_core #(
  parameter int unsigned MAX_DIGITS = ddsplit_pkg::MaxDigitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire ddsplit_pkg::item_t   item_i,
  output logic                      busy_o,
  output logic                      res_valid_o,
  output ddsplit_pkg::result_t      res_o
);

  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);

  logic                       job_valid, job_pop;
  ddsplit_pkg::job_t          job;
  logic                       hand_valid, hand_ready;
  logic [MAX_DIGITS-1:0][3:0] digits;
  logic [CntW-1:0]            count;
  ddsplit_pkg::place_t        place;

  ddsplit_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .job_valid_o(job_valid),
    .job_o      (job),
    .job_pop_i  (job_pop)
  );

  ddsplit_conv #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .hand_valid_o(hand_valid),
    .hand_ready_i(hand_ready),
    .digits_o    (digits),
    .count_o     (count),
    .place_o     (place)
  );

  ddsplit_emit #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hand_valid_i(hand_valid),
    .hand_ready_o(hand_ready),
    .digits_i    (digits),
    .count_i     (count),
    .place_i     (place),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // A number's beats are contiguous: a beat that is not the last is followed by another.
  a_beats_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_digit |=> res_valid_o)
    else $error("digit beats of one number were interrupted");

  // Within one number, each column sits six to the left of the previous one.
  a_column_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_digit |=>
      res_o.digit_column == 8'($past(res_o.digit_column) - ddsplit_pkg::ColumnStep))
    else $error("digit column did not step by six");

  // Every emitted digit is a decimal digit.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.decimal_digit <= 4'd9)
    else $error("emitted digit above nine");

  // The converter never hands off while the emitter still has beats left.
  a_hand_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hand_valid && hand_ready && res_valid_o |-> res_o.last_digit)
    else $error("handoff overwrote an unfinished number");

endmodule

`default_nettype wire
